// ===== src/sha1hs_pkg.sv =====
// ----------------------------------------------------------------------------
// sha1hs_pkg
// Shared types, constants and round functions of the SHA-1 byte-stream hasher.
// ----------------------------------------------------------------------------
`default_nettype none

package sha1hs_pkg;

    // Default depth of the item queue between the front and the back.
    localparam int QUEUE_DEPTH = 4;

    // Number of compression rounds per 512-bit block.
    localparam int ROUNDS = 80;

    // Number of digest words.
    localparam int DIGEST_WORDS = 5;

    // First padding byte and the byte slot where the length field begins.
    localparam logic [7:0] PAD_BYTE = 8'h80;
    localparam logic [5:0] LEN_POS  = 6'd56;
    localparam logic [5:0] LAST_POS = 6'd63;

    // Initial chaining value, word 0 at index 0.
    localparam logic [4:0][31:0] H_INIT = {
        32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301
    };

    // Round constants.
    localparam logic [31:0] K0 = 32'h5A827999;
    localparam logic [31:0] K1 = 32'h6ED9EBA1;
    localparam logic [31:0] K2 = 32'h8F1BBCDC;
    localparam logic [31:0] K3 = 32'hCA62C1D6;

    // One message item as it travels through the queue.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_present;
        logic       last_byte;
    } t_item;

    // Rotate left by a constant amount.
    function automatic logic [31:0] rotl(input logic [31:0] v, input int unsigned s);
        rotl = (v << s) | (v >> (32 - s));
    endfunction

    // Round function selected by the round number.
    function automatic logic [31:0] f_round(input logic [6:0] t, input logic [31:0] b,
                                            input logic [31:0] c, input logic [31:0] d);
        if (t < 7'd20) begin
            f_round = (b & c) | (~b & d);
        end else if (t < 7'd40) begin
            f_round = b ^ c ^ d;
        end else if (t < 7'd60) begin
            f_round = (b & c) | (b & d) | (c & d);
        end else begin
            f_round = b ^ c ^ d;
        end
    endfunction

    // Round constant selected by the round number.
    function automatic logic [31:0] k_round(input logic [6:0] t);
        if (t < 7'd20) begin
            k_round = K0;
        end else if (t < 7'd40) begin
            k_round = K1;
        end else if (t < 7'd60) begin
            k_round = K2;
        end else begin
            k_round = K3;
        end
    endfunction

endpackage

`default_nettype wire

// ===== src/sha1_hash_stream.sv =====
// ----------------------------------------------------------------------------
// sha1_hash_stream
// SHA-1 digest over a byte stream, one message byte per item.
// ----------------------------------------------------------------------------
// Each item carries one byte (byte_present) and an end mark (last_byte). The
// engine takes bytes from the queue while it loads a block; every 64th byte
// starts a compression (80 rounds on one shared round unit plus the chaining
// add), during which it takes no bytes. On the end mark the engine inserts
// padding at one byte a cycle, which costs one or two more compressions,
// then presents the five digest words h0 first, one per accepted cycle. A
// queue of QUEUE_DEPTH items ahead of the engine keeps taking input while
// the engine hashes or the digest waits. Items with neither a byte nor an
// end mark are dropped.
// ----------------------------------------------------------------------------
`default_nettype none

module sha1_hash_stream #(
    parameter int QUEUE_DEPTH = sha1hs_pkg::QUEUE_DEPTH
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_valid,
    output logic              o_stall,
    input  wire logic [7:0]   i_data_byte,
    input  wire logic         i_byte_present,
    input  wire logic         i_last_byte,
    output logic              o_valid,
    input  wire logic         i_stall,
    output logic [31:0]       o_digest_word,
    output logic [2:0]        o_word_index,
    output logic              o_last_word
);

    logic              f_push;
    sha1hs_pkg::t_item f_item;
    logic              q_ready;
    logic              q_valid;
    sha1hs_pkg::t_item q_item;
    logic              q_pop;

    // Input stage.
    sha1hs_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_data_byte    (i_data_byte),
        .i_byte_present (i_byte_present),
        .i_last_byte    (i_last_byte),
        .o_push         (f_push),
        .o_item         (f_item),
        .i_push_ready   (q_ready)
    );

    // Item queue.
    sha1hs_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_push),
        .i_item  (f_item),
        .o_ready (q_ready),
        .o_valid (q_valid),
        .o_item  (q_item),
        .i_pop   (q_pop)
    );

    // Hash engine.
    sha1hs_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_valid     (q_valid),
        .i_q_item      (q_item),
        .o_q_pop       (q_pop),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_digest_word (o_digest_word),
        .o_word_index  (o_word_index),
        .o_last_word   (o_last_word)
    );

endmodule

`default_nettype wire

// ===== src/sha1hs_front.sv =====
// ----------------------------------------------------------------------------
// sha1hs_front
// Input stage: registers each item, drops idle items and pushes the rest
// into the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module sha1hs_front (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire logic [7:0]         i_data_byte,
    input  wire logic               i_byte_present,
    input  wire logic               i_last_byte,
    output logic                    o_push,
    output sha1hs_pkg::t_item       o_item,
    input  wire logic               i_push_ready
);

    logic              r_valid;
    sha1hs_pkg::t_item r_item;
    logic              accept;
    logic              useful;

    // The holding register is free when empty or when it drains this cycle.
    assign o_stall = r_valid && !i_push_ready;
    assign accept  = i_valid && !o_stall;
    assign useful  = i_byte_present || i_last_byte;

    // An item without a byte and without an end mark does nothing and is dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= useful;
        end else if (i_push_ready) begin
            r_valid <= 1'b0;
        end
    end

    // Payload capture.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item.data_byte    <= i_data_byte;
            r_item.byte_present <= i_byte_present;
            r_item.last_byte    <= i_last_byte;
        end
    end

    assign o_push = r_valid;
    assign o_item = r_item;

endmodule

`default_nettype wire

// ===== src/sha1hs_queue.sv =====
// ----------------------------------------------------------------------------
// sha1hs_queue
// Short register queue that decouples the input stage from the hash engine.
// ----------------------------------------------------------------------------
`default_nettype none

module sha1hs_queue #(
    parameter int DEPTH = sha1hs_pkg::QUEUE_DEPTH
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_push,
    input  wire sha1hs_pkg::t_item  i_item,
    output logic                    o_ready,
    output logic                    o_valid,
    output sha1hs_pkg::t_item       o_item,
    input  wire logic               i_pop
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    sha1hs_pkg::t_item r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr;
    logic [CNT_W-1:0]  r_count;
    logic              do_push;
    logic              do_pop;

    assign o_ready = (r_count != CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd_ptr];
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // Storage write.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

`default_nettype wire

// ===== src/sha1hs_back.sv =====
// ----------------------------------------------------------------------------
// sha1hs_back
// Hash engine: packs bytes into the block, pads the message, runs one
// compression round per cycle and delivers the five digest words.
// ----------------------------------------------------------------------------
`default_nettype none

module sha1hs_back (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_q_valid,
    input  wire sha1hs_pkg::t_item  i_q_item,
    output logic                    o_q_pop,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic [31:0]             o_digest_word,
    output logic [2:0]              o_word_index,
    output logic                    o_last_word
);

    typedef enum logic [4:0] {
        S_LOAD = 5'b00001,
        S_PAD  = 5'b00010,
        S_HASH = 5'b00100,
        S_ADD  = 5'b01000,
        S_OUT  = 5'b10000
    } t_state;

    t_state            r_state;
    t_state            n_state;
    logic [5:0]        r_pos;
    logic [60:0]       r_bytes;
    logic              r_pad;
    logic              r_sent80;
    logic              r_lenon;
    logic              r_fin;
    logic [6:0]        r_round;
    logic [2:0]        r_idx;
    logic [4:0][31:0]  r_h;
    logic [4:0][31:0]  r_v;
    logic [511:0]      r_blk;

    logic              ins_en;
    logic [7:0]        ins_byte;
    logic              len_eff;
    logic [63:0]       len_bits;
    logic [2:0]        len_sel;
    logic              blk_full;
    logic [31:0]       w_next;
    logic [31:0]       round_sum;
    logic              out_take;

    assign len_bits = {r_bytes, 3'b000};
    assign len_sel  = 3'd7 - r_pos[2:0];
    assign len_eff  = r_sent80 && (r_lenon || (r_pos == sha1hs_pkg::LEN_POS));
    assign blk_full = (r_pos == sha1hs_pkg::LAST_POS);
    assign out_take = (r_state == S_OUT) && !i_stall;
    assign o_q_pop  = (r_state == S_LOAD) && i_q_valid;

    // Byte source for the block register: message bytes or padding bytes.
    always_comb begin
        ins_en   = 1'b0;
        ins_byte = '0;
        if (r_state == S_LOAD) begin
            ins_en   = i_q_valid && i_q_item.byte_present;
            ins_byte = i_q_item.data_byte;
        end else if (r_state == S_PAD) begin
            ins_en = 1'b1;
            if (!r_sent80) begin
                ins_byte = sha1hs_pkg::PAD_BYTE;
            end else if (len_eff) begin
                ins_byte = len_bits[{len_sel, 3'b000} +: 8];
            end
        end
    end

    // Message schedule and round sum from the 16-word window.
    assign w_next    = sha1hs_pkg::rotl(r_blk[511:480] ^ r_blk[447:416]
                                        ^ r_blk[255:224] ^ r_blk[95:64], 1);
    assign round_sum = sha1hs_pkg::rotl(r_v[0], 5)
                       + sha1hs_pkg::f_round(r_round, r_v[1], r_v[2], r_v[3])
                       + r_v[4] + sha1hs_pkg::k_round(r_round) + r_blk[511:480];

    // Sequencer next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_LOAD: begin
                if (i_q_valid) begin
                    if (i_q_item.byte_present && blk_full) begin
                        n_state = S_HASH;
                    end else if (i_q_item.last_byte) begin
                        n_state = S_PAD;
                    end
                end
            end
            S_PAD: begin
                if (blk_full) begin
                    n_state = S_HASH;
                end
            end
            S_HASH: begin
                if (r_round == 7'(sha1hs_pkg::ROUNDS - 1)) begin
                    n_state = S_ADD;
                end
            end
            S_ADD: begin
                if (r_fin) begin
                    n_state = S_OUT;
                end else if (r_pad) begin
                    n_state = S_PAD;
                end else begin
                    n_state = S_LOAD;
                end
            end
            S_OUT: begin
                if (!i_stall && (r_idx == 3'(sha1hs_pkg::DIGEST_WORDS - 1))) begin
                    n_state = S_LOAD;
                end
            end
            default: n_state = S_LOAD;
        endcase
    end

    // Control state: position, length, padding flags, round and word counters.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_LOAD;
            r_pos    <= '0;
            r_bytes  <= '0;
            r_pad    <= 1'b0;
            r_sent80 <= 1'b0;
            r_lenon  <= 1'b0;
            r_fin    <= 1'b0;
            r_round  <= '0;
            r_idx    <= '0;
            r_h      <= sha1hs_pkg::H_INIT;
        end else begin
            r_state <= n_state;
            if (ins_en) begin
                r_pos <= r_pos + 1'b1;
            end
            if (o_q_pop && i_q_item.byte_present) begin
                r_bytes <= r_bytes + 1'b1;
            end
            if (o_q_pop && i_q_item.last_byte) begin
                r_pad <= 1'b1;
            end
            if (r_state == S_PAD) begin
                r_sent80 <= 1'b1;
                if (len_eff) begin
                    r_lenon <= 1'b1;
                    if (blk_full) begin
                        r_fin <= 1'b1;
                    end
                end
            end
            if (r_state == S_HASH) begin
                r_round <= r_round + 1'b1;
            end else begin
                r_round <= '0;
            end
            // Fold the round result into the chaining words.
            if (r_state == S_ADD) begin
                for (int i = 0; i < 5; i++) begin
                    r_h[i] <= r_h[i] + r_v[i];
                end
            end
            // Each delivered word shifts out; the initial value shifts in behind it.
            if (out_take) begin
                r_h[3:0] <= r_h[4:1];
                r_h[4]   <= sha1hs_pkg::H_INIT[r_idx];
                r_idx    <= r_idx + 1'b1;
                if (r_idx == 3'(sha1hs_pkg::DIGEST_WORDS - 1)) begin
                    r_idx    <= '0;
                    r_bytes  <= '0;
                    r_pad    <= 1'b0;
                    r_sent80 <= 1'b0;
                    r_lenon  <= 1'b0;
                    r_fin    <= 1'b0;
                end
            end
        end
    end

    // Block register: bytes shift in, and during the rounds words shift through.
    always_ff @(posedge i_clk) begin
        if (ins_en) begin
            r_blk <= {r_blk[503:0], ins_byte};
        end else if (r_state == S_HASH) begin
            r_blk <= {r_blk[479:0], w_next};
        end
    end

    // Working variables: loaded from the chaining words, then one round a cycle.
    always_ff @(posedge i_clk) begin
        if (n_state == S_HASH && r_state != S_HASH) begin
            r_v <= r_h;
        end else if (r_state == S_HASH) begin
            r_v[4] <= r_v[3];
            r_v[3] <= r_v[2];
            r_v[2] <= sha1hs_pkg::rotl(r_v[1], 30);
            r_v[1] <= r_v[0];
            r_v[0] <= round_sum;
        end
    end

    assign o_valid       = (r_state == S_OUT);
    assign o_digest_word = r_h[0];
    assign o_word_index  = r_idx;
    assign o_last_word   = (r_idx == 3'(sha1hs_pkg::DIGEST_WORDS - 1));

endmodule

`default_nettype wire

// ===== src/sha1hs_checker.sv =====
// ----------------------------------------------------------------------------
// sha1hs_checker
// Port-level checks on the digest output of the SHA-1 byte-stream hasher.
// ----------------------------------------------------------------------------
`default_nettype none

module sha1hs_checker (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_out_valid,
    input  wire logic         i_out_stall,
    input  wire logic [31:0]  i_digest_word,
    input  wire logic [2:0]   i_word_index,
    input  wire logic         i_last_word
);

    // A stalled digest word stays offered and unchanged.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_stall |=>
            i_out_valid && $stable(i_digest_word) && $stable(i_word_index))
        else $error("digest word changed while stalled");

    // Word positions stay within the five digest words.
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_word_index <= 3'd4))
        else $error("digest word index out of range");

    // The final flag marks exactly the fifth word.
    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_last_word == (i_word_index == 3'd4)))
        else $error("last word flag disagrees with index");

    // Digest words follow one another without gaps.
    a_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_stall && !i_last_word |=>
            i_out_valid && (i_word_index == $past(i_word_index) + 3'd1))
        else $error("digest words not delivered in sequence");

endmodule

bind sha1_hash_stream sha1hs_checker u_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_out_valid   (o_valid),
    .i_out_stall   (i_stall),
    .i_digest_word (o_digest_word),
    .i_word_index  (o_word_index),
    .i_last_word   (o_last_word)
);

`default_nettype wire

// ===== sim/tb_sha1_hash_stream.sv =====
// ----------------------------------------------------------------------------
// tb_sha1_hash_stream
// Self-checking testbench for the SHA-1 byte-stream hasher.
// ----------------------------------------------------------------------------
// A queue of message items is built up front: a few directed messages and
// then random messages of mixed lengths, with the block boundary lengths
// favored. Idle items and empty end marks are mixed in as noise. A clocked
// driver feeds the queue to the hasher with random idle bursts. A clocked
// monitor runs a software SHA-1 on every accepted item and checks each
// accepted digest word against the oldest predicted word. Output stalls come
// in random bursts, and both sides run without gaps near the end.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_sha1_hash_stream;

    // Initial chaining value, h0 in the top word.
    localparam logic [159:0] SEED_CHAIN = {
        32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
    };

    // Round constants of the four round groups.
    localparam logic [31:0] RC_CHOOSE = 32'h5A827999;
    localparam logic [31:0] RC_PARITY = 32'h6ED9EBA1;
    localparam logic [31:0] RC_MAJOR  = 32'h8F1BBCDC;
    localparam logic [31:0] RC_TAIL   = 32'hCA62C1D6;

    // Padding marker and the byte slot where the length field starts.
    localparam logic [7:0] PAD_MARK = 8'h80;
    localparam logic [5:0] LEN_SLOT = 6'd56;
    localparam logic [5:0] END_SLOT = 6'd63;

    // Stimulus sizing and the drain wait after the last item.
    localparam int TARGET_ITEMS = 430;
    localparam int QUIET_ITEMS  = 60;
    localparam int DRAIN_CYCLES = 400;

    // One pending input item with its idle gap and drain hold.
    typedef struct {
        logic [7:0] data;
        logic       present;
        logic       last;
        int         gap;
        logic       hold;
    } t_feed_item;

    // One predicted digest word.
    typedef struct {
        logic [31:0] word;
        logic [2:0]  idx;
        logic        last;
    } t_digest_entry;

    logic        i_clk          = 1'b0;
    logic        i_rst_n        = 1'b0;
    logic        i_valid        = 1'b0;
    logic [7:0]  i_data_byte    = 8'h00;
    logic        i_byte_present = 1'b0;
    logic        i_last_byte    = 1'b0;
    logic        i_stall        = 1'b0;
    logic        o_stall;
    logic        o_valid;
    logic [31:0] o_digest_word;
    logic [2:0]  o_word_index;
    logic        o_last_word;

    t_feed_item    feed_q[$];
    t_digest_entry digest_q[$];

    // Predictor state.
    logic [31:0] chain [5];
    logic [31:0] blk [16];
    logic [5:0]  blk_pos;
    logic [63:0] msg_bits;

    int fail_count = 0;
    int feed_count = 0;
    int gap_cnt    = 0;
    int stall_cnt  = 0;
    int cycle_cnt  = 0;

    sha1_hash_stream dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_data_byte    (i_data_byte),
        .i_byte_present (i_byte_present),
        .i_last_byte    (i_last_byte),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_digest_word  (o_digest_word),
        .o_word_index   (o_word_index),
        .o_last_word    (o_last_word)
    );

    // Clock with a period of 8.
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic logic [31:0] rol32(input logic [31:0] v, input int unsigned n);
        rol32 = (v << n) | (v >> (32 - n));
    endfunction

    // Return the chaining value, byte slot and length to their start values.
    task automatic sha1_restart();
        int k;
        for (k = 0; k < 5; k++) begin
            chain[k] = SEED_CHAIN[159 - 32 * k -: 32];
        end
        blk_pos  = '0;
        msg_bits = '0;
    endtask

    // Run the 80 rounds over the current block and fold into the chain.
    task automatic sha1_compress();
        logic [31:0] w [80];
        logic [31:0] a, b, c, d, e, f, rc, sum;
        int t;
        for (t = 0; t < 16; t++) begin
            w[t] = blk[t];
        end
        for (t = 16; t < 80; t++) begin
            w[t] = rol32(w[t - 3] ^ w[t - 8] ^ w[t - 14] ^ w[t - 16], 1);
        end
        a = chain[0];
        b = chain[1];
        c = chain[2];
        d = chain[3];
        e = chain[4];
        for (t = 0; t < 80; t++) begin
            if (t < 20) begin
                f  = (b & c) | (~b & d);
                rc = RC_CHOOSE;
            end else if (t < 40) begin
                f  = b ^ c ^ d;
                rc = RC_PARITY;
            end else if (t < 60) begin
                f  = (b & c) | (b & d) | (c & d);
                rc = RC_MAJOR;
            end else begin
                f  = b ^ c ^ d;
                rc = RC_TAIL;
            end
            sum = rol32(a, 5) + f + e + rc + w[t];
            e = d;
            d = c;
            c = rol32(b, 30);
            b = a;
            a = sum;
        end
        chain[0] = chain[0] + a;
        chain[1] = chain[1] + b;
        chain[2] = chain[2] + c;
        chain[3] = chain[3] + d;
        chain[4] = chain[4] + e;
    endtask

    // Place one byte big-endian into the block and compress when it fills.
    task automatic sha1_absorb(input logic [7:0] v);
        logic [31:0] lane;
        lane = {24'h0, v} << ((3 - blk_pos[1:0]) * 8);
        if (blk_pos[1:0] == 2'd0) begin
            blk[blk_pos[5:2]] = lane;
        end else begin
            blk[blk_pos[5:2]] = blk[blk_pos[5:2]] | lane;
        end
        if (blk_pos == END_SLOT) begin
            sha1_compress();
            blk_pos = '0;
        end else begin
            blk_pos = blk_pos + 6'd1;
        end
    endtask

    // Advance the predictor by one accepted item; an end mark pads and
    // queues the five digest words.
    task automatic sha1_take_item(input logic [7:0] data, input logic present,
                                  input logic last);
        t_digest_entry ent;
        int k;
        if (present) begin
            sha1_absorb(data);
            msg_bits = msg_bits + 64'd8;
        end
        if (last) begin
            sha1_absorb(PAD_MARK);
            while (blk_pos != LEN_SLOT) begin
                sha1_absorb(8'h00);
            end
            for (k = 7; k >= 0; k--) begin
                sha1_absorb(msg_bits[k * 8 +: 8]);
            end
            for (k = 0; k < 5; k++) begin
                ent.word = chain[k];
                ent.idx  = k[2:0];
                ent.last = (k == 4);
                digest_q.insert(digest_q.size(), ent);
            end
            sha1_restart();
        end
    endtask

    // Append one item to the feed queue; gaps vanish for busy items and in the closing stretch.
    task automatic add_item(input logic [7:0] data, input logic present,
                            input logic last, input logic busy, input logic hold);
        t_feed_item it;
        it.data    = data;
        it.present = present;
        it.last    = last;
        it.hold    = hold;
        if (busy || feed_count >= TARGET_ITEMS - QUIET_ITEMS) begin
            it.gap = 0;
        end else begin
            it.gap = ($urandom_range(0, 3) == 0) ? int'($urandom_range(1, 12)) : 0;
        end
        if (present || last) begin
            feed_count++;
        end
        feed_q.insert(feed_q.size(), it);
    endtask

    // Driver: present the next item whenever the slot frees up, after any idle gap and drain hold.
    always @(posedge i_clk) begin
        t_feed_item cur;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            gap_cnt <= 0;
        end else if (!i_valid || !o_stall) begin
            if (gap_cnt != 0) begin
                i_valid <= 1'b0;
                gap_cnt <= gap_cnt - 1;
            end else if (feed_q.size() != 0 &&
                         !(feed_q[0].hold && (i_valid || digest_q.size() != 0))) begin
                cur = feed_q.pop_front();
                i_valid        <= 1'b1;
                i_data_byte    <= cur.data;
                i_byte_present <= cur.present;
                i_last_byte    <= cur.last;
                gap_cnt        <= (feed_q.size() != 0) ? feed_q[0].gap : 0;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Output stall in bursts, with calm stretches and none near the end.
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (!i_rst_n) begin
            i_stall   <= 1'b0;
            stall_cnt <= 0;
        end else if (stall_cnt != 0) begin
            i_stall   <= 1'b1;
            stall_cnt <= stall_cnt - 1;
        end else if (feed_q.size() > QUIET_ITEMS && cycle_cnt[10] == 1'b0 &&
                     $urandom_range(0, 5) == 0) begin
            i_stall   <= 1'b1;
            stall_cnt <= $urandom_range(0, 11);
        end else begin
            i_stall <= 1'b0;
        end
    end

    // Monitor: predict on accepted inputs, check accepted digest words.
    always @(posedge i_clk) begin
        t_digest_entry exp_w;
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                sha1_take_item(i_data_byte, i_byte_present, i_last_byte);
            end
            if (o_valid && !i_stall) begin
                if (digest_q.size() == 0) begin
                    $error("unexpected digest word %h (index %0d)",
                           o_digest_word, o_word_index);
                    fail_count++;
                end else begin
                    exp_w = digest_q.pop_front();
                    if (o_digest_word !== exp_w.word) begin
                        $error("digest_word: expected %h, got %h", exp_w.word, o_digest_word);
                        fail_count++;
                    end
                    if (o_word_index !== exp_w.idx) begin
                        $error("word_index: expected %0d, got %0d", exp_w.idx, o_word_index);
                        fail_count++;
                    end
                    if (o_last_word !== exp_w.last) begin
                        $error("last_word: expected %b, got %b", exp_w.last, o_last_word);
                        fail_count++;
                    end
                end
            end
        end
    end

    // Stimulus, reset and end of run.
    initial begin
        int   len, j, pick;
        logic busy, hold, sep_end;
        int   boundary [7];
        boundary = '{55, 56, 63, 64, 65, 119, 120};

        sha1_restart();

        // Directed: empty message, idle item, "abc", single extreme bytes,
        // an end mark without a byte, and an empty message right after.
        add_item(8'h00, 1'b0, 1'b1, 1'b0, 1'b0);
        add_item(8'hA5, 1'b0, 1'b0, 1'b0, 1'b0);
        add_item(8'h61, 1'b1, 1'b0, 1'b0, 1'b0);
        add_item(8'h62, 1'b1, 1'b0, 1'b0, 1'b0);
        add_item(8'h63, 1'b1, 1'b1, 1'b0, 1'b0);
        add_item(8'hFF, 1'b1, 1'b1, 1'b0, 1'b0);
        add_item(8'h00, 1'b1, 1'b1, 1'b0, 1'b0);
        add_item(8'h61, 1'b1, 1'b0, 1'b0, 1'b0);
        add_item(8'h62, 1'b1, 1'b0, 1'b0, 1'b0);
        add_item(8'hFF, 1'b0, 1'b1, 1'b0, 1'b0);
        add_item(8'h5A, 1'b0, 1'b1, 1'b0, 1'b0);

        // Random part: mostly whole messages, some noise and bare end marks.
        // A pending drain hold stays armed until a message item takes it.
        hold = 1'b1;
        while (feed_count < TARGET_ITEMS) begin
            pick = $urandom_range(0, 19);
            busy = ($urandom_range(0, 3) == 0);
            if (pick < 2) begin
                add_item(8'($urandom), 1'b0, 1'b0, busy, 1'b0);
            end else if (pick < 3) begin
                add_item(8'($urandom), 1'b0, 1'b1, busy, hold);
                hold = 1'b0;
            end else begin
                case ($urandom_range(0, 9)) inside
                    [0:4]:   len = $urandom_range(1, 20);
                    [5:7]:   len = boundary[$urandom_range(0, 6)];
                    default: len = $urandom_range(1, 130);
                endcase
                sep_end = ($urandom_range(0, 3) == 0);
                for (j = 0; j < len; j++) begin
                    if ($urandom_range(0, 19) == 0) begin
                        add_item(8'($urandom), 1'b0, 1'b0, busy, 1'b0);
                    end
                    add_item(8'($urandom), 1'b1, !sep_end && (j == len - 1), busy,
                             hold && (j == 0));
                    hold = 1'b0;
                end
                if (sep_end) begin
                    add_item(8'($urandom), 1'b0, 1'b1, busy, 1'b0);
                end
            end
            hold = hold || (feed_count < TARGET_ITEMS - QUIET_ITEMS &&
                            $urandom_range(0, 14) == 0);
        end

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (feed_q.size() != 0 || i_valid) begin
            @(posedge i_clk);
        end
        while (digest_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // Watchdog.
    initial begin
        #4000000;
        $display("TEST FAILED");
        $finish;
    end

endmodule

`default_nettype wire

// ===== filelist.f =====
src/sha1hs_pkg.sv
src/sha1hs_front.sv
src/sha1hs_queue.sv
src/sha1hs_back.sv
src/sha1_hash_stream.sv
src/sha1hs_checker.sv
sim/tb_sha1_hash_stream.sv
